// ===== hdl/lkv_pkg.sv =====
// Package for the LRU key/value cache.
// Field widths, reset values, action codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic load_req;
        logic capture;
        logic update;
        logic load_rsp;
    } t_cmd;

    typedef struct packed {
        logic is_put;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/lkv_if.sv =====
// Channel interfaces of the LRU key/value cache: request, response and configuration.
// Depends on lkv_pkg.
`default_nettype none

interface lkv_req_if import lkv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: joins controller, datapath and channels.
// Depends on lkv_pkg, lkv_if, lkv_ctrl and lkv_dp.
`default_nettype none

// A fully associative key/value store with least-recently-used replacement.
// Each request is a get or a put; a get produces one response transfer, a put
// produces none. The block handles one request at a time. After the accepting edge
// a put keeps it busy through match, then rank and memory update. A get keeps it
// busy through match, rank update with the value memory read, and response load;
// the response load waits until the response register is free.
// A new request may be accepted while the last response still waits in the
// output register. Valid bits are cleared by reset, so no clearing pass is run.
// Capacity writes take effect at once and are meant for an idle block; zero acts
// as one and values above ENTRIES act as ENTRIES.
module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lkv_req_if.sink    i_req,
    lkv_rsp_if.source  o_rsp,
    lkv_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_req.action),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_hit        (o_rsp.hit),
        .o_read_value (o_rsp.read_value)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while a request is in progress");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.hit |-> o_rsp.read_value == '0)
        else $error("miss response carries a nonzero value");

    a_rsp_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_rsp |-> !o_rsp.valid || o_rsp.ready)
        else $error("response register overwritten before transfer");

    a_put_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update && sts.is_put |=> !cmd.load_rsp && i_req.ready)
        else $error("put did not return to idle");

endmodule

`default_nettype wire

// ===== hdl/lkv_ctrl.sv =====
// Controller of the LRU key/value cache: sequences match, update and response.
// Depends on lkv_pkg.
`default_nettype none

module lkv_ctrl import lkv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.capture = 1'b1;
                n_state       = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.is_put ? S_IDLE : S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_rsp) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lkv_dp.sv =====
// Datapath of the LRU key/value cache: key cells, value memory, recency ranks,
// fill count, capacity register and the response register. Depends on lkv_pkg.
`default_nettype none

module lkv_dp import lkv_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_sts                         o_sts,
    input  wire logic                    i_action,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CAP_W-1:0]        i_cfg_data,
    output logic                         o_hit,
    output logic signed [VAL_W-1:0]      o_read_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int FW = $clog2(ENTRIES + 1);

    logic                    r_action;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [CAP_W-1:0]        r_capacity;

    logic signed [KEY_W-1:0] r_keys [ENTRIES];
    logic signed [VAL_W-1:0] r_val_mem [ENTRIES];
    logic [ENTRIES-1:0]      r_valid;
    logic [RW-1:0]           r_rank [ENTRIES];
    logic [FW-1:0]           r_fill;

    logic                    r_hit;
    logic [IW-1:0]           r_hit_idx;
    logic [RW-1:0]           r_hit_rank;
    logic [IW-1:0]           r_free_idx;
    logic [IW-1:0]           r_victim_idx;
    logic                    r_do_fill;
    logic signed [VAL_W-1:0] r_rd_value;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] oldest;
    logic [IW-1:0]      n_hit_idx;
    logic [IW-1:0]      n_free_idx;
    logic [IW-1:0]      n_victim_idx;
    logic [FW-1:0]      eff_cap;
    logic [RW-1:0]      last_rank;
    logic [IW-1:0]      target;
    logic               is_put;
    logic               touch_en;

    assign last_rank = RW'(r_fill - FW'(1));

    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = FW'(1);
        end else if (int'(r_capacity) > ENTRIES) begin
            eff_cap = FW'(ENTRIES);
        end else begin
            eff_cap = FW'(r_capacity);
        end
    end

    always_comb begin
        n_hit_idx    = '0;
        n_free_idx   = '0;
        n_victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_keys[i] == r_key);
            oldest[i] = r_valid[i] && (r_rank[i] == last_rank);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                n_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                n_free_idx = IW'(i);
            end
            if (oldest[i]) begin
                n_victim_idx = IW'(i);
            end
        end
    end

    assign is_put   = (r_action == ACT_PUT);
    assign touch_en = r_hit || is_put;
    assign target   = r_hit ? r_hit_idx : (r_do_fill ? r_free_idx : r_victim_idx);
    assign o_sts.is_put = is_put;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_value  <= i_value;
        end
        if (i_cmd.capture) begin
            r_hit        <= |match;
            r_hit_idx    <= n_hit_idx;
            r_hit_rank   <= r_rank[n_hit_idx];
            r_free_idx   <= n_free_idx;
            r_victim_idx <= n_victim_idx;
            r_do_fill    <= (r_fill < eff_cap);
        end
        if (i_cmd.update && is_put && !r_hit) begin
            r_keys[target] <= r_key;
        end
        if (i_cmd.load_rsp) begin
            o_hit        <= r_hit;
            o_read_value <= r_hit ? r_rd_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && is_put) begin
            r_val_mem[target] <= r_value;
        end
        r_rd_value <= r_val_mem[r_hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_valid    <= '0;
            r_fill     <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.update && touch_en) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (IW'(i) != target) &&
                        (!r_hit || (r_rank[i] < r_hit_rank))) begin
                        r_rank[i] <= r_rank[i] + RW'(1);
                    end
                end
                r_rank[target] <= '0;
                if (!r_hit && r_do_fill) begin
                    r_valid[target] <= 1'b1;
                    r_fill          <= r_fill + FW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire
